### rtl/core/arphr_pkg.sv
`timescale 1ns / 1ps
package arphr_pkg;

  localparam int FRAC_BITS = 16;
  localparam int TIME_W    = 32;

  localparam int CODE_W    = 12;
  localparam int TSTAMP_W  = 32;
  localparam int MENV_W    = 12;
  localparam int IVL_W     = 16;
  localparam int RATE_W    = 12;
  localparam int CFG_W     = 16;

  localparam int IN_TDATA_W  = ((CODE_W + TSTAMP_W + 7) / 8) * 8;
  localparam int OUT_FLD_W   = RATE_W + 2;
  localparam int OUT_TDATA_W = ((OUT_FLD_W + 7) / 8) * 8;
  localparam int OUT_PAD     = OUT_TDATA_W - OUT_FLD_W;

  // converter code to millivolts: round(code * 3300 * 2^F / 4095)
  localparam int MV_FULL   = 3300;
  localparam int MV_FULL_W = 12;
  localparam int ADC_MAX   = 4095;
  localparam int ADC_HALF  = 2047;

  localparam int MV_W   = MV_FULL_W + FRAC_BITS;
  localparam int ST_W   = MV_W + 4;
  localparam int THR_W  = ST_W + 1;
  localparam int DIF_W  = ST_W + 2;
  localparam int COEF_W = FRAC_BITS + 1;
  localparam int PROD_W = DIF_W + COEF_W;

  // serial divider
  localparam int DIVD_W = CODE_W + MV_FULL_W + FRAC_BITS;
  localparam int DSR_W  = IVL_W;
  localparam int CNT_W  = $clog2(DIVD_W + 1);

  // rate = round(960000 / interval), saturated
  localparam int RATE_NUM   = 960000;
  localparam int RATE_NUM_W = 20;
  localparam int RATE_MAX   = 4095;

  localparam longint ONE_Q = longint'(1) << FRAC_BITS;
  localparam logic [COEF_W-1:0] A_BASE = COEF_W'((ONE_Q * 1 + 500) / 1000);
  localparam logic [COEF_W-1:0] A_ATT  = COEF_W'((ONE_Q * 15 + 50) / 100);
  localparam logic [COEF_W-1:0] A_DEC  = COEF_W'((ONE_Q * 2 + 500) / 1000);

  localparam logic [MENV_W-1:0] MENV_RST = MENV_W'(100);
  localparam logic [IVL_W-1:0]  MINV_RST = IVL_W'(300);
  localparam logic [IVL_W-1:0]  MAXV_RST = IVL_W'(2000);

  typedef enum logic [1:0] {
    CFG_MIN_ENV = 2'd0,
    CFG_MIN_IVL = 2'd1,
    CFG_MAX_IVL = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic capture;
    logic div_start;
    logic div_sel_rate;
    logic mv_load;
    logic base_mul;
    logic base_upd;
    logic env_mul;
    logic env_upd;
    logic thresh;
    logic decide;
    logic rate_load;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic rate_go;
  } stat_t;

endpackage

### rtl/core/arphr_div.sv
`timescale 1ns / 1ps
module arphr_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [arphr_pkg::DIVD_W-1:0]  dividend,
  input  logic [arphr_pkg::DSR_W-1:0]   divisor,
  input  logic [arphr_pkg::CNT_W-1:0]   steps,
  output logic                          done,
  output logic [arphr_pkg::DIVD_W-1:0]  quotient
);
  import arphr_pkg::*;

  logic [DIVD_W-1:0] quo_r, quo_nxt;
  logic [DSR_W-1:0]  rem_r, rem_nxt;
  logic [DSR_W-1:0]  dsr_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [DSR_W:0]    trial;
  logic [DSR_W:0]    diff;
  logic              ge;

  // restoring division, one quotient bit per cycle
  always_comb begin
    trial   = {rem_r, quo_r[DIVD_W-1]};
    diff    = trial - {1'b0, dsr_r};
    ge      = trial >= {1'b0, dsr_r};
    rem_nxt = ge ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
    quo_nxt = {quo_r[DIVD_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

### rtl/core/arphr_datapath.sv
`timescale 1ns / 1ps
module arphr_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [arphr_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic [arphr_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                              cfg_we,
  input  logic [1:0]                        cfg_index,
  input  logic [arphr_pkg::CFG_W-1:0]       cfg_wdata,
  input  arphr_pkg::cmd_t                   cmd,
  output arphr_pkg::stat_t                  stat
);
  import arphr_pkg::*;

  logic [MENV_W-1:0] menv_r;
  logic [IVL_W-1:0]  minv_r;
  logic [IVL_W-1:0]  maxv_r;

  logic [CODE_W-1:0] code_r;
  logic [TIME_W-1:0] time_r;
  logic [MV_W-1:0]   mv_r;
  logic signed [ST_W-1:0]   b_r;
  logic signed [ST_W-1:0]   env_r;
  logic signed [PROD_W-1:0] prod_r;
  logic              above_r;
  logic              was_r;
  logic [TIME_W-1:0] last_r;
  logic              have_r;
  logic [IVL_W-1:0]  intv_r;
  logic [RATE_W-1:0] rate_r;
  logic              beat_r;
  logic              upd_r;
  logic              ob_r;
  logic              ou_r;
  logic [RATE_W-1:0] orate_r;

  logic [DIVD_W-1:0] red_r;
  logic [MV_W-1:0]   acc_r;
  logic              mvb_r;
  logic              mvd_r;

  logic [DIVD_W-1:0] div_dvd;
  logic [DSR_W-1:0]  div_dsr;
  logic [CNT_W-1:0]  div_steps;
  logic              div_done;
  logic [DIVD_W-1:0] div_quo;
  logic              div_go;

  logic [DIVD_W-1:0]        mv_dvd;
  logic [DIVD_W-CODE_W-1:0] red_hi;
  logic [CODE_W-1:0]        red_lo;
  logic                     mv_go;

  logic signed [ST_W-1:0]   mv_s;
  logic signed [DIF_W-1:0]  dev;
  logic signed [DIF_W-1:0]  mul_a;
  logic signed [COEF_W-1:0] coef;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] shr;
  logic signed [ST_W-1:0]   floor_q;
  logic signed [ST_W-1:0]   env_used;
  logic signed [THR_W-1:0]  thr;
  logic [TIME_W-1:0]        intv;
  logic                     beat;
  logic                     in_win;
  logic [RATE_NUM_W-1:0]    rq;

  always_comb begin
    div_go    = cmd.div_start && cmd.div_sel_rate;
    mv_go     = cmd.div_start && !cmd.div_sel_rate;
    div_dvd   = (DIVD_W'(RATE_NUM) + DIVD_W'(intv_r >> 1)) << (DIVD_W - RATE_NUM_W);
    div_dsr   = intv_r;
    div_steps = CNT_W'(RATE_NUM_W);
    mv_dvd    = ((DIVD_W'(code_r) * DIVD_W'(MV_FULL)) << FRAC_BITS) + DIVD_W'(ADC_HALF);
    red_hi    = red_r[DIVD_W-1:CODE_W];
    red_lo    = red_r[CODE_W-1:0];
  end

  arphr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_go),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .steps    (div_steps),
    .done     (div_done),
    .quotient (div_quo)
  );

  // divide by 4095 = 2^12 - 1: fold the high part back onto the low part
  // until it fits in 12 bits, then one final compare
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mvb_r <= 1'b0;
      mvd_r <= 1'b0;
    end else begin
      mvd_r <= 1'b0;
      if (mv_go) begin
        mvb_r <= 1'b1;
      end else if (mvb_r && (red_hi == '0)) begin
        mvb_r <= 1'b0;
        mvd_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mv_go) begin
      red_r <= mv_dvd;
      acc_r <= '0;
    end else if (mvb_r) begin
      if (red_hi != '0) begin
        acc_r <= acc_r + MV_W'(red_hi);
        red_r <= DIVD_W'(red_lo) + DIVD_W'(red_hi);
      end else if (red_lo == CODE_W'(ADC_MAX)) begin
        acc_r <= acc_r + MV_W'(1);
        red_r <= '0;
      end
    end
  end

  always_comb begin
    mv_s = $signed(ST_W'(mv_r));
    dev  = DIF_W'(mv_s) - DIF_W'(b_r);
    if (cmd.env_mul) begin
      mul_a = dev - DIF_W'(env_r);
      coef  = (dev > DIF_W'(env_r)) ? $signed(A_ATT) : $signed(A_DEC);
    end else begin
      mul_a = dev;
      coef  = $signed(A_BASE);
    end
    prod = mul_a * coef;
    shr  = prod_r >>> FRAC_BITS;

    floor_q  = $signed(ST_W'({menv_r, {FRAC_BITS{1'b0}}}));
    env_used = (env_r > floor_q) ? env_r : floor_q;
    thr      = THR_W'(b_r) + THR_W'(env_used >>> 1);

    intv   = time_r - last_r;
    beat   = above_r && !was_r;
    in_win = (intv > TIME_W'(minv_r)) && (intv < TIME_W'(maxv_r));
    rq     = div_quo[RATE_NUM_W-1:0];
  end

  assign stat.div_done = div_done || mvd_r;
  assign stat.rate_go  = beat && have_r && in_win;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      menv_r <= MENV_RST;
      minv_r <= MINV_RST;
      maxv_r <= MAXV_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_MIN_ENV: menv_r <= cfg_wdata[MENV_W-1:0];
        CFG_MIN_IVL: minv_r <= cfg_wdata[IVL_W-1:0];
        CFG_MAX_IVL: maxv_r <= cfg_wdata[IVL_W-1:0];
        default: ;
      endcase
    end
  end

  // detector state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_r    <= '0;
      env_r  <= '0;
      was_r  <= 1'b0;
      last_r <= '0;
      have_r <= 1'b0;
      rate_r <= '0;
    end else begin
      if (cmd.base_upd) begin
        b_r <= b_r + shr[ST_W-1:0];
      end
      if (cmd.env_upd) begin
        env_r <= env_r + shr[ST_W-1:0];
      end
      if (cmd.decide) begin
        was_r <= above_r;
        if (beat) begin
          last_r <= time_r;
          have_r <= 1'b1;
        end
      end
      if (cmd.rate_load) begin
        rate_r <= (rq > RATE_NUM_W'(RATE_MAX)) ? RATE_W'(RATE_MAX) : rq[RATE_W-1:0];
      end
    end
  end

  // per-request working registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      code_r <= in_tdata[CODE_W-1:0];
      time_r <= in_tdata[CODE_W +: TIME_W];
    end
    if (cmd.mv_load) begin
      mv_r <= acc_r;
    end
    if (cmd.base_mul || cmd.env_mul) begin
      prod_r <= prod;
    end
    if (cmd.thresh) begin
      above_r <= THR_W'(mv_s) > thr;
    end
    if (cmd.decide) begin
      intv_r <= intv[IVL_W-1:0];
      beat_r <= beat;
      upd_r  <= 1'b0;
    end
    if (cmd.rate_load) begin
      upd_r <= 1'b1;
    end
    if (cmd.out_load) begin
      ob_r    <= beat_r;
      ou_r    <= upd_r;
      orate_r <= rate_r;
    end
  end

  assign out_tdata = {{OUT_PAD{1'b0}}, orate_r, ou_r, ob_r};

endmodule

### rtl/core/arphr_ctrl.sv
`timescale 1ns / 1ps
module arphr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  arphr_pkg::stat_t  stat,
  output arphr_pkg::cmd_t   cmd
);
  import arphr_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MV_GO,
    S_MV_WAIT,
    S_BASE_MUL,
    S_BASE_UPD,
    S_ENV_MUL,
    S_ENV_UPD,
    S_THRESH,
    S_DECIDE,
    S_RATE_GO,
    S_RATE_WAIT,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_MV_GO;
        end
      end
      S_MV_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_MV_WAIT;
      end
      S_MV_WAIT: begin
        if (stat.div_done) begin
          cmd.mv_load = 1'b1;
          state_nxt   = S_BASE_MUL;
        end
      end
      S_BASE_MUL: begin
        cmd.base_mul = 1'b1;
        state_nxt    = S_BASE_UPD;
      end
      S_BASE_UPD: begin
        cmd.base_upd = 1'b1;
        state_nxt    = S_ENV_MUL;
      end
      S_ENV_MUL: begin
        cmd.env_mul = 1'b1;
        state_nxt   = S_ENV_UPD;
      end
      S_ENV_UPD: begin
        cmd.env_upd = 1'b1;
        state_nxt   = S_THRESH;
      end
      S_THRESH: begin
        cmd.thresh = 1'b1;
        state_nxt  = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt  = stat.rate_go ? S_RATE_GO : S_FINISH;
      end
      S_RATE_GO: begin
        cmd.div_start    = 1'b1;
        cmd.div_sel_rate = 1'b1;
        state_nxt        = S_RATE_WAIT;
      end
      S_RATE_WAIT: begin
        cmd.div_sel_rate = 1'b1;
        if (stat.div_done) begin
          cmd.rate_load = 1'b1;
          state_nxt     = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  a_load_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_tready))
    else $error("result register overwritten while occupied");

  a_done_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    stat.div_done |-> (state_r == S_MV_WAIT || state_r == S_RATE_WAIT))
    else $error("divider finished outside a wait state");

  a_accept_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> cmd.div_start)
    else $error("accepted request did not start scaling");

  a_one_step: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.capture, cmd.div_start, cmd.mv_load, cmd.base_mul, cmd.base_upd,
              cmd.env_mul, cmd.env_upd, cmd.thresh, cmd.decide, cmd.rate_load,
              cmd.out_load}))
    else $error("more than one datapath step at once");

endmodule

### rtl/core/adaptive_r_peak_heart_rate_core.sv
`timescale 1ns / 1ps
// Adaptive-threshold R-peak detector with heart-rate estimate.
// in_*  : one request per ECG sample; in_tdata = {time_ms[31:0], sample_code[11:0]}.
// out_* : one result per request; out_tdata = {heart_rate_x16, rate_updated,
//         beat_detected}, padded to 16 bits.
// cfg_* : write-only registers, cfg_index 0 = min_envelope_mv, 1 = min_interval_ms,
//         2 = max_interval_ms; other indexes are ignored. Write only while idle.
// One request is processed at a time; the next request can be taken in the
// cycle after the previous result is loaded into the output register.
// Scaling the code to millivolts folds by 4095, taking longer for some codes than
// others; the rate uses a 20-step serial divider. in_tready is high only while no
// request is in flight.
// The result sits in an output register, so the next request is accepted while
// it waits; if the receiver stalls, the following result is held back until the
// register drains, and no further request is taken until then.
// Reset (rst_n low at a clock edge) clears baseline, envelope, beat history and
// rate, and loads the registers with 100 mV, 300 ms and 2000 ms.
module adaptive_r_peak_heart_rate_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [11:0] sample_code, [43:12] time_ms
  input  logic [arphr_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [0] beat_detected, [1] rate_updated, [13:2] heart_rate_x16
  output logic [arphr_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                              cfg_we,
  input  logic [1:0]                        cfg_index,
  input  logic [arphr_pkg::CFG_W-1:0]       cfg_wdata
);
  import arphr_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  arphr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  arphr_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule
